// ===== src/lqa_pkg.sv =====
// Shared types, widths and helpers for the laminar quota admission block.
package lqa_pkg;

  localparam int ELEM_W  = 8;
  localparam int MASK_W  = 16;
  localparam int GIDX_W  = 4;
  localparam int COUNT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [MASK_W-1:0]  mask_t;

  typedef enum logic [2:0] {
    OP_LOAD_MASK = 3'd0,
    OP_LOAD_CAP  = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_CAN_ADD   = 3'd3,
    OP_CAN_SWAP  = 3'd4,
    OP_ADD       = 3'd5,
    OP_REMOVE    = 3'd6,
    OP_SET_ITEM  = 3'd7
  } op_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == COUNT_MAX) ? v : count_t'(v + 1'b1);
  endfunction

  function automatic count_t sat_dec(input count_t v);
    return (v == '0) ? v : count_t'(v - 1'b1);
  endfunction

endpackage

// ===== src/laminar_quota_admission.sv =====
// Laminar quota admission: hierarchical group quota checker, top level.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | opcode element swap_element group_mask
//          |                      | group_index capacity last
//  out     | out_valid / out_ready| allowed element_present current_feasible status
//
// Throughput is one transaction per cycle while the result register is not
// stalled and no clear or sweep holds the input. The input stage captures the
// transaction and reads the group mask and held bit of element and swap_element
// from the mask and held memories (registered read ports). The result stage
// evaluates the groups in parallel against the live counters and capacities,
// commits state and loads the result register.
// After reset both memories are swept to zero, one entry per cycle, over all
// entries; in_ready stays low during the sweep. A clear closes the input from
// its capture; once it commits, the held memory is swept with in_ready low.
// A stalled result register holds; one more transaction can still be taken
// into the input stage before in_ready drops.
module laminar_quota_admission #(
  parameter int NUM_ELEMENTS = 256,
  parameter int NUM_GROUPS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  lqa_pkg::op_t                   opcode,
  input  logic [lqa_pkg::ELEM_W-1:0]     element,
  input  logic [lqa_pkg::ELEM_W-1:0]     swap_element,
  input  logic [lqa_pkg::MASK_W-1:0]     group_mask,
  input  logic [lqa_pkg::GIDX_W-1:0]     group_index,
  input  logic [lqa_pkg::COUNT_W-1:0]    capacity,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           allowed,
  output logic                           element_present,
  output logic                           current_feasible,
  output logic                           status
);
  import lqa_pkg::*;

  localparam int IW = $clog2(NUM_ELEMENTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ELEMENTS - 1);

  // ---------------- clearing sweep ----------------
  logic          clearing;
  logic          clr_masks;   // only the sweep after reset zeroes the masks
  logic [IW-1:0] clr_idx;
  logic          clr_start;

  // ---------------- handshake ----------------
  logic v1;       // input stage holds a transaction
  logic adv;      // input stage moves into the result register
  logic in_fire;

  // ---------------- input stage ----------------
  op_t                op_q;
  logic [IW-1:0]      e_idx, s_idx;
  logic               e_ok, s_ok;
  logic [GIDX_W-1:0]  gidx_q;
  count_t             cap_q;
  logic               last_q;

  // a clear waiting in the input stage keeps the input closed
  assign adv       = v1 && (!out_valid || out_ready);
  assign in_ready  = !clearing && (!v1 || (adv && op_q != OP_CLEAR));
  assign in_fire   = in_valid && in_ready;
  assign clr_start = adv && op_q == OP_CLEAR;

  // ---------------- mask memory ----------------
  logic [IW-1:0] ein_idx, sin_idx;
  logic          ein_ok, sin_ok;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  mask_t         mem_wdata;
  mask_t         mask_mem [NUM_ELEMENTS];
  mask_t         em_rd, sm_rd;

  assign ein_idx = IW'(element);
  assign sin_idx = IW'(swap_element);
  assign ein_ok  = 32'(element) < NUM_ELEMENTS;
  assign sin_ok  = 32'(swap_element) < NUM_ELEMENTS;

  // Mask loads commit at capture; the next transaction's read sees them.
  assign mem_we    = (clearing && clr_masks) ||
                     (in_fire && opcode == OP_LOAD_MASK && ein_ok);
  assign mem_waddr = clearing ? clr_idx : ein_idx;
  assign mem_wdata = clearing ? '0 : group_mask;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      em_rd <= mask_mem[ein_idx];
      sm_rd <= mask_mem[sin_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_fire) begin
      v1 <= 1'b1;
    end else if (adv) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q   <= opcode;
      e_idx  <= ein_idx;
      s_idx  <= sin_idx;
      e_ok   <= ein_ok;
      s_ok   <= sin_ok;
      gidx_q <= group_index;
      cap_q  <= capacity;
      last_q <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_masks <= 1'b1;
      clr_idx   <= '0;
    end else if (clearing) begin
      if (clr_idx == LAST_IDX) begin
        clearing  <= 1'b0;
        clr_masks <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end else if (clr_start) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end
  end

  // ---------------- group state ----------------
  count_t                  counts     [NUM_GROUPS];
  count_t                  caps       [NUM_GROUPS];
  count_t                  scratch    [NUM_GROUPS];
  logic                    viol;

  count_t                  counts_next  [NUM_GROUPS];
  count_t                  caps_next    [NUM_GROUPS];
  count_t                  scratch_next [NUM_GROUPS];
  logic                    viol_next;

  logic                    held_set, held_drop;
  logic                    allowed_c, present_c, feasible_c, status_c;

  mask_t                   em, sm;
  logic [NUM_GROUPS-1:0]   em_g, sm_g, room;
  logic                    held_e, held_s;

  // ---------------- held-bit memory ----------------
  logic          held_mem [NUM_ELEMENTS];
  logic          held_we;
  logic [IW-1:0] held_waddr;
  logic          held_wdata;
  logic          he_rd, hs_rd;

  assign held_we    = clearing || (adv && (held_set || held_drop));
  assign held_waddr = clearing ? clr_idx : e_idx;
  assign held_wdata = !clearing && held_set;

  // a capture in the same cycle as a commit sees the committed bit
  always_ff @(posedge clk) begin
    if (held_we) begin
      held_mem[held_waddr] <= held_wdata;
    end
    if (in_fire) begin
      he_rd <= (held_we && held_waddr == ein_idx) ? held_wdata : held_mem[ein_idx];
      hs_rd <= (held_we && held_waddr == sin_idx) ? held_wdata : held_mem[sin_idx];
    end
  end

  assign em     = e_ok ? em_rd : '0;
  assign sm     = s_ok ? sm_rd : '0;
  assign em_g   = NUM_GROUPS'(em);   // groups beyond the mask width are never members
  assign sm_g   = NUM_GROUPS'(sm);
  assign held_e = e_ok && he_rd;
  assign held_s = s_ok && hs_rd;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      room[g] = counts[g] < caps[g];
    end
  end

  always_comb begin
    logic v_tmp;
    v_tmp      = viol;
    viol_next  = viol;
    held_set   = 1'b0;
    held_drop  = 1'b0;
    allowed_c  = 1'b0;
    status_c   = 1'b0;
    present_c  = held_e;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      counts_next[g]  = counts[g];
      caps_next[g]    = caps[g];
      scratch_next[g] = scratch[g];
    end

    case (op_q)
      OP_LOAD_MASK: begin
      end
      OP_LOAD_CAP: begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          if (int'(gidx_q) == g) begin
            caps_next[g] = cap_q;
          end
        end
      end
      OP_CLEAR: begin
        // held bits are cleared by the sweep that follows the commit
        for (int g = 0; g < NUM_GROUPS; g++) begin
          counts_next[g]  = '0;
          scratch_next[g] = '0;
        end
        viol_next  = 1'b0;
        present_c  = 1'b0;
      end
      OP_CAN_ADD: begin
        if (held_e) begin
          status_c = 1'b1;
        end else begin
          allowed_c = ~|(em_g & ~room);
        end
      end
      OP_CAN_SWAP: begin
        // a full group is fine when the outgoing element is in it
        if (held_e || !held_s) begin
          status_c = 1'b1;
        end else begin
          allowed_c = ~|(em_g & ~room & ~sm_g);
        end
      end
      OP_ADD: begin
        if (!e_ok || held_e) begin
          status_c = 1'b1;
        end else begin
          for (int g = 0; g < NUM_GROUPS; g++) begin
            if (em_g[g]) begin
              counts_next[g] = sat_inc(counts[g]);
            end
          end
          held_set  = 1'b1;
          present_c = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!e_ok || !held_e) begin
          status_c = 1'b1;
        end else begin
          for (int g = 0; g < NUM_GROUPS; g++) begin
            if (em_g[g]) begin
              counts_next[g] = sat_dec(counts[g]);
            end
          end
          held_drop = 1'b1;
          present_c = 1'b0;
        end
      end
      OP_SET_ITEM: begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
          if (em_g[g]) begin
            scratch_next[g] = sat_inc(scratch[g]);
            if (scratch_next[g] > caps[g]) begin
              v_tmp = 1'b1;
            end
          end
        end
        allowed_c = !v_tmp;
        viol_next = v_tmp;
        if (last_q) begin
          for (int g = 0; g < NUM_GROUPS; g++) begin
            scratch_next[g] = '0;
          end
          viol_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    feasible_c = 1'b1;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (counts_next[g] > caps_next[g]) begin
        feasible_c = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        counts[g]  <= '0;
        caps[g]    <= '0;
        scratch[g] <= '0;
      end
      viol <= 1'b0;
    end else if (adv) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        counts[g]  <= counts_next[g];
        caps[g]    <= caps_next[g];
        scratch[g] <= scratch_next[g];
      end
      viol <= viol_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      allowed          <= allowed_c;
      element_present  <= present_c;
      current_feasible <= feasible_c;
      status           <= status_c;
    end
  end

endmodule

// ===== src/lqa_checker.sv =====
// Port-level assertions for the laminar quota admission block, with bind.
module lqa_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic allowed,
  input logic element_present,
  input logic current_feasible,
  input logic status
);

  // mask memory sweep keeps the input closed right after reset
  a_no_accept_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high in the cycle after reset");

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high in the cycle after reset");

  // a failed precondition never admits
  a_status_blocks_allowed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !allowed)
    else $error("allowed set together with status");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable(allowed) && $stable(element_present) &&
      $stable(current_feasible) && $stable(status))
    else $error("stalled result changed");

endmodule

bind laminar_quota_admission lqa_checker u_lqa_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .allowed          (allowed),
  .element_present  (element_present),
  .current_feasible (current_feasible),
  .status           (status)
);

// ===== tb/testbench.sv =====
// Self-checking testbench: directed table, set-check burst and random traffic.
module testbench;
  import lqa_pkg::*;

  typedef struct packed {
    op_t          op;
    logic [7:0]   elem;
    logic [7:0]   swap;
    mask_t        gmask;
    logic [3:0]   gidx;
    count_t       cap;
    logic         fin;
  } txn_t;

  // One result transaction, in port order.
  typedef struct packed {
    logic allowed;
    logic present;
    logic feasible;
    logic status;
  } verdict_t;

  // Directed row: stimulus plus an optional hand-typed verdict.
  typedef struct packed {
    txn_t     t;
    logic     pin;
    verdict_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  op_t opcode;
  logic [ELEM_W-1:0] element;
  logic [ELEM_W-1:0] swap_element;
  logic [MASK_W-1:0] group_mask;
  logic [GIDX_W-1:0] group_index;
  logic [COUNT_W-1:0] capacity;
  logic last;
  logic out_valid;
  logic out_ready = 1'b0;
  logic allowed;
  logic element_present;
  logic current_feasible;
  logic status;

  laminar_quota_admission dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .element          (element),
    .swap_element     (swap_element),
    .group_mask       (group_mask),
    .group_index      (group_index),
    .capacity         (capacity),
    .last             (last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .allowed          (allowed),
    .element_present  (element_present),
    .current_feasible (current_feasible),
    .status           (status)
  );

  always #2 clk = ~clk;

  // Shadow copy of the block state; all zero out of reset.
  mask_t  group_of [256];
  bit     held_now [256];
  count_t live_cnt [16];
  count_t quota    [16];
  count_t probe_cnt[16];
  bit     probe_over;

  verdict_t pending_verdicts[$];
  logic     pin_now;
  verdict_t want_now;
  bit       calm;
  int       mismatches;
  int       taken;
  int       checked;
  int       refusals;
  int       over_quota;

  function automatic bit has_room(input int g);
    return int'(live_cnt[g]) + 1 <= int'(quota[g]);
  endfunction

  // Applies one transaction to the shadow state and returns its verdict.
  function automatic verdict_t admission_verdict(input txn_t t);
    verdict_t v;
    mask_t    em;
    mask_t    sm;
    int       g;
    v = '0;
    em = group_of[t.elem];
    sm = group_of[t.swap];
    case (t.op)
      OP_LOAD_MASK: group_of[t.elem] = t.gmask;
      OP_LOAD_CAP:  quota[t.gidx] = t.cap;
      OP_CLEAR: begin
        foreach (held_now[i]) held_now[i] = 1'b0;
        for (g = 0; g < 16; g++) begin
          live_cnt[g] = '0;
          probe_cnt[g] = '0;
        end
        probe_over = 1'b0;
      end
      OP_CAN_ADD: begin
        if (held_now[t.elem]) begin
          v.status = 1'b1;
        end else begin
          v.allowed = 1'b1;
          for (g = 0; g < 16; g++)
            if (em[g] && !has_room(g)) v.allowed = 1'b0;
        end
      end
      OP_CAN_SWAP: begin
        if (held_now[t.elem] || !held_now[t.swap]) begin
          v.status = 1'b1;
        end else begin
          // a full group is fine if the outgoing element frees a slot in it
          v.allowed = 1'b1;
          for (g = 0; g < 16; g++)
            if (em[g] && !has_room(g) && !sm[g]) v.allowed = 1'b0;
        end
      end
      OP_ADD: begin
        if (held_now[t.elem]) begin
          v.status = 1'b1;
        end else begin
          for (g = 0; g < 16; g++)
            if (em[g] && live_cnt[g] != '1) live_cnt[g] = live_cnt[g] + 1'b1;
          held_now[t.elem] = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!held_now[t.elem]) begin
          v.status = 1'b1;
        end else begin
          // uses the current mask, so a reloaded mask can floor counts at zero
          for (g = 0; g < 16; g++)
            if (em[g] && live_cnt[g] != '0) live_cnt[g] = live_cnt[g] - 1'b1;
          held_now[t.elem] = 1'b0;
        end
      end
      OP_SET_ITEM: begin
        for (g = 0; g < 16; g++) begin
          if (em[g]) begin
            if (probe_cnt[g] != '1) probe_cnt[g] = probe_cnt[g] + 1'b1;
            if (probe_cnt[g] > quota[g]) probe_over = 1'b1;
          end
        end
        v.allowed = !probe_over;
        if (t.fin) begin
          for (g = 0; g < 16; g++) probe_cnt[g] = '0;
          probe_over = 1'b0;
        end
      end
      default: ;
    endcase
    v.feasible = 1'b1;
    for (g = 0; g < 16; g++)
      if (live_cnt[g] > quota[g]) v.feasible = 1'b0;
    v.present = held_now[t.elem];
    return v;
  endfunction

  task automatic check_bit(input string name, input logic exp, input logic got);
    if (got !== exp) begin
      $error("%s: expected %0b, got %0b", name, exp, got);
      mismatches++;
    end
  endtask

  // Scoreboard: retire results first, then log the transaction taken at this edge.
  verdict_t seen_v;
  verdict_t next_v;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result transaction with no verdict pending");
          mismatches++;
        end else begin
          seen_v = pending_verdicts.pop_front();
          check_bit("allowed", seen_v.allowed, allowed);
          check_bit("element_present", seen_v.present, element_present);
          check_bit("current_feasible", seen_v.feasible, current_feasible);
          check_bit("status", seen_v.status, status);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        next_v = admission_verdict('{opcode, element, swap_element, group_mask,
                                     group_index, capacity, last});
        if (pin_now) next_v = want_now;
        pending_verdicts.push_back(next_v);
        taken++;
        if (next_v.status) refusals++;
        if (!next_v.feasible) over_quota++;
      end
    end
  end

  // Result side back-pressure: out_ready drops with a chance of 17 in 100, never when calm.
  always @(negedge clk) out_ready <= calm || ($urandom_range(99) >= 17);

  task automatic offer(input txn_t t, input logic pin, input verdict_t want);
    if (!calm && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= t.op;
    element      <= t.elem;
    swap_element <= t.swap;
    group_mask   <= t.gmask;
    group_index  <= t.gidx;
    capacity     <= t.cap;
    last         <= t.fin;
    pin_now      <= pin;
    want_now     <= want;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random traffic biased toward a small element pool so adds, removes and
  // swaps keep hitting held elements and small quotas keep filling up.
  function automatic txn_t pick_txn();
    txn_t t;
    int   r;
    int   k;
    int   c;
    t.elem = 8'($urandom);
    t.swap = 8'($urandom);
    t.gmask = 16'($urandom);
    t.gidx = 4'($urandom);
    t.cap = 9'($urandom);
    t.fin = 1'($urandom);
    r = $urandom_range(99);
    if (r < 8)       t.op = OP_LOAD_MASK;
    else if (r < 14) t.op = OP_LOAD_CAP;
    else if (r < 16) t.op = OP_CLEAR;
    else if (r < 30) t.op = OP_CAN_ADD;
    else if (r < 44) t.op = OP_CAN_SWAP;
    else if (r < 64) t.op = OP_ADD;
    else if (r < 80) t.op = OP_REMOVE;
    else             t.op = OP_SET_ITEM;
    if ($urandom_range(3) != 0) t.elem = 8'($urandom_range(23));
    if ($urandom_range(2) != 0)
      t.gmask = (16'h1 << $urandom_range(15)) | (16'h1 << $urandom_range(15));
    if ($urandom_range(3) != 0) t.cap = 9'($urandom_range(6));
    if (t.op == OP_CAN_SWAP && $urandom_range(4) != 0) begin
      for (k = 0; k < 8; k++) begin
        c = $urandom_range(23);
        if (held_now[c]) begin
          t.swap = 8'(c);
          break;
        end
      end
    end
    if (t.op == OP_SET_ITEM) t.fin = ($urandom_range(4) == 0);
    return t;
  endfunction

  // Directed table; a pin of 1 means the verdict {allowed, present,
  // feasible, status} is typed in, else the predictor supplies it.
  row_t plan [26] = '{
    '{'{OP_CAN_ADD,   8'd0,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b1010},
    '{'{OP_REMOVE,    8'd255, 8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0011},
    '{'{OP_CAN_SWAP,  8'd1,   8'd255, 16'h0000, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0011},
    '{'{OP_LOAD_MASK, 8'd0,   8'd0,   16'hFFFF, 4'd15, 9'd511, 1'b1}, 1'b1, 4'b0010},
    '{'{OP_LOAD_MASK, 8'd255, 8'd0,   16'h8001, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0010},
    '{'{OP_LOAD_CAP,  8'd0,   8'd0,   16'h0000, 4'd0,  9'd256, 1'b0}, 1'b1, 4'b0010},
    '{'{OP_LOAD_CAP,  8'd0,   8'd0,   16'h0000, 4'd15, 9'd511, 1'b0}, 1'b1, 4'b0010},
    '{'{OP_LOAD_CAP,  8'd0,   8'd0,   16'h0000, 4'd1,  9'd1,   1'b0}, 1'b1, 4'b0010},
    // most groups have zero quota, so the all-groups element is refused
    '{'{OP_CAN_ADD,   8'd0,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0010},
    '{'{OP_ADD,       8'd0,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0100},
    '{'{OP_ADD,       8'd0,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0101},
    '{'{OP_CAN_ADD,   8'd0,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0101},
    '{'{OP_CAN_SWAP,  8'd255, 8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b0, 4'b0000},
    '{'{OP_LOAD_MASK, 8'd7,   8'd0,   16'h0002, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0000},
    // group 1 is full but the outgoing element sits in it
    '{'{OP_CAN_SWAP,  8'd7,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b0, 4'b0000},
    '{'{OP_CAN_ADD,   8'd7,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b0, 4'b0000},
    '{'{OP_REMOVE,    8'd0,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0010},
    // streamed set: second copy overflows group 1, flag sticks until last
    '{'{OP_SET_ITEM,  8'd7,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b0, 4'b0000},
    '{'{OP_SET_ITEM,  8'd7,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b0, 4'b0000},
    '{'{OP_SET_ITEM,  8'd255, 8'd0,   16'h0000, 4'd0,  9'd0,   1'b1}, 1'b0, 4'b0000},
    '{'{OP_SET_ITEM,  8'd7,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b1}, 1'b0, 4'b0000},
    // mask reloaded while held, then removed: counts floor at zero
    '{'{OP_ADD,       8'd255, 8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b0, 4'b0000},
    '{'{OP_LOAD_MASK, 8'd255, 8'd0,   16'hFFFF, 4'd0,  9'd0,   1'b0}, 1'b0, 4'b0000},
    '{'{OP_REMOVE,    8'd255, 8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b0, 4'b0000},
    '{'{OP_ADD,       8'd7,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b0, 4'b0000},
    '{'{OP_CLEAR,     8'd7,   8'd0,   16'h0000, 4'd0,  9'd0,   1'b0}, 1'b1, 4'b0010}
  };

  initial begin
    txn_t t;
    int   i;
    foreach (group_of[j]) group_of[j] = '0;
    foreach (live_cnt[j]) begin
      live_cnt[j]  = '0;
      quota[j]     = '0;
      probe_cnt[j] = '0;
    end
    probe_over = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_LOAD_MASK;
    element = '0;
    swap_element = '0;
    group_mask = '0;
    group_index = '0;
    capacity = '0;
    last = 1'b0;
    pin_now = 1'b0;
    want_now = '0;
    calm = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[j]) offer(plan[j].t, plan[j].pin, plan[j].want);

    // Long streamed set on group 15 (quota 511): scratch count must stop at 511
    // without raising the violation flag.
    t = '{OP_LOAD_MASK, 8'd200, 8'd0, 16'h8000, 4'd0, 9'd0, 1'b0};
    offer(t, 1'b0, '0);
    for (i = 0; i < 512; i++) begin
      t = pick_txn();
      t.op = OP_SET_ITEM;
      t.elem = 8'd200;
      t.fin = (i == 511);
      offer(t, 1'b0, '0);
    end

    for (i = 0; i < 160; i++) begin
      calm = (i >= 50 && i < 110);
      offer(pick_txn(), 1'b0, '0);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d transactions taken, %0d results checked", taken, checked);
    $display("%0d precondition refusals, %0d over-quota results", refusals, over_quota);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
